FILE: rtl/core/pro_pkg.sv
// Package with the shared types, codes and defaults of the priority retransmit outbox.
package pro_pkg;

	// Default number of descriptor slots.
	localparam int DEPTH_DEFAULT = 16;

	// Reset values of the configuration registers.
	localparam logic [23:0] MAX_BYTES_RESET  = 24'd1048576;
	localparam logic [31:0] TIMEOUT_MS_RESET = 32'd0;

	// Configuration register indexes, taken from paddr[2].
	localparam logic REG_MAX_BYTES  = 1'b0;
	localparam logic REG_TIMEOUT_MS = 1'b1;

	// Operation codes.
	localparam logic [3:0] MODE_PUT       = 4'd0;
	localparam logic [3:0] MODE_DISPATCH  = 4'd1;
	localparam logic [3:0] MODE_RETRY     = 4'd2;
	localparam logic [3:0] MODE_ACK       = 4'd3;
	localparam logic [3:0] MODE_CLR_FLT   = 4'd4;
	localparam logic [3:0] MODE_PEEK_HEAD = 4'd5;
	localparam logic [3:0] MODE_PEEK_REG  = 4'd6;
	localparam logic [3:0] MODE_TIMEOUT   = 4'd7;
	localparam logic [3:0] MODE_CLR_ALL   = 4'd8;

	// Status codes.
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_DUP       = 3'd1;
	localparam logic [2:0] ST_REJECT    = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;
	localparam logic [2:0] ST_NO_ENTRY  = 3'd5;

	// One descriptor as held in the slot memory.
	typedef struct packed {
		logic [63:0] id_high;
		logic [63:0] id_low;
		logic [63:0] sent_time;
		logic [15:0] size;
		logic [15:0] tag;
		logic        prio;
		logic        flight;
	} slot_t;

endpackage

FILE: rtl/core/priority_retransmit_outbox.sv
// Top level of the priority retransmit outbox: sequencer, order memory and registers.
//
// Channel   | Signals                                   | Transaction
// command   | start, busy, mode, id_*, payload_*, ...   | start high while busy low
// result    | done, status, found_*, timeout_seen, ...  | done high for one cycle
// config    | psel, penable, pwrite, paddr, pwdata, ... | access phase with pready high
//
// Each operation walks the queue one position at a time, with an order memory
// read, a slot memory read and an evaluate step per position.
// Put and ack then shift the order memory, with a read and a write per moved position.
// Rejected puts, unknown modes, clear all and a disabled timeout check finish without a scan.
// After reset the block stays busy while the order memory is loaded with the
// slot numbers. The receiver of results cannot stall the block.
module priority_retransmit_outbox #(
	parameter int DEPTH = pro_pkg::DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [3:0]  mode,
	input  logic [63:0] id_high,
	input  logic [63:0] id_low,
	input  logic [15:0] payload_tag,
	input  logic [15:0] payload_len,
	input  logic        priority_req,
	input  logic [63:0] time_ms,
	output logic        done,
	output logic [2:0]  status,
	output logic [63:0] found_id_high,
	output logic [63:0] found_id_low,
	output logic [15:0] found_tag,
	output logic [15:0] found_size,
	output logic        found_priority,
	output logic        timeout_seen,
	output logic [4:0]  queued_count,
	output logic [23:0] queued_bytes,
	output logic [4:0]  inflight_count,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);
	localparam logic [CW-1:0] LAST = CW'(DEPTH - 1);

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_ORD, S_SLOT, S_EVAL, S_MISS,
		S_PUT_FREE, S_PUT_WR, S_SH_RD, S_SH_WR, S_TAIL
	} state_t;

	state_t         state_q;
	logic [CW-1:0]  p_q;
	logic [CW-1:0]  held_q;
	logic [CW-1:0]  sending_q;
	logic [23:0]    bytes_q;
	logic [23:0]    max_bytes_q;
	logic [31:0]    timeout_q;
	logic [IW-1:0]  cur_slot_q;
	logic [IW-1:0]  free_q;
	logic [IW-1:0]  tail_q;
	logic [CW-1:0]  first_reg_q;
	logic           reg_seen_q;
	logic           right_q;
	logic           done_q;

	// Latched command fields.
	logic [3:0]     mode_q;
	logic [63:0]    idh_q;
	logic [63:0]    idl_q;
	logic [15:0]    tag_q;
	logic [15:0]    size_q;
	logic           prio_q;
	logic [63:0]    now_q;

	// Result registers.
	logic [2:0]     status_q;
	pro_pkg::slot_t found_q;
	logic           tmo_q;

	// Order memory and slot memory ports.
	logic [IW-1:0]  ord_mem [DEPTH];
	logic [IW-1:0]  ord_rdata;
	logic [IW-1:0]  ord_raddr;
	logic           ord_we;
	logic [IW-1:0]  ord_waddr;
	logic [IW-1:0]  ord_wdata;
	logic           slot_we;
	logic [IW-1:0]  slot_waddr;
	pro_pkg::slot_t slot_wdata;
	logic [IW-1:0]  slot_raddr;
	pro_pkg::slot_t slot_rdata;

	// Evaluation of the entry under the scan.
	logic           id_match;
	logic [64:0]    age;
	logic           timed_out;
	logic           reject;
	logic [24:0]    room;
	logic [IW-1:0]  sh_src;
	logic [IW-1:0]  sh_next;

	assign id_match  = (slot_rdata.id_high == idh_q) && (slot_rdata.id_low == idl_q);
	assign age       = {1'b0, now_q} - {1'b0, slot_rdata.sent_time};
	assign timed_out = slot_rdata.flight && !age[64] && (age[63:0] >= {32'd0, timeout_q});
	assign room      = {1'b0, max_bytes_q} - {9'd0, payload_len};
	assign reject    = (payload_len == 16'd0) || room[24] || ({1'b0, bytes_q} > room);
	assign sh_src    = right_q ? (p_q[IW-1:0] - IW'(1)) : (p_q[IW-1:0] + IW'(1));
	assign sh_next   = sh_src;

	// Order memory.
	always_ff @(posedge clk) begin
		if (ord_we) begin
			ord_mem[ord_waddr] <= ord_wdata;
		end
		ord_rdata <= ord_mem[ord_raddr];
	end

	pro_slot_ram #(.DEPTH(DEPTH)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	// Memory addressing and write data for each step.
	always_comb begin
		ord_raddr  = p_q[IW-1:0];
		ord_we     = 1'b0;
		ord_waddr  = p_q[IW-1:0];
		ord_wdata  = ord_rdata;
		slot_raddr = ord_rdata;
		slot_we    = 1'b0;
		slot_waddr = cur_slot_q;
		slot_wdata = slot_rdata;
		case (state_q)
			S_INIT: begin
				ord_we    = 1'b1;
				ord_wdata = p_q[IW-1:0];
			end
			S_PUT_FREE: ord_raddr = held_q[IW-1:0];
			S_PUT_WR: begin
				slot_we    = 1'b1;
				slot_waddr = ord_rdata;
				slot_wdata = '{id_high: idh_q, id_low: idl_q, sent_time: 64'd0,
					size: size_q, tag: tag_q, prio: prio_q, flight: 1'b0};
			end
			S_SH_RD: ord_raddr = sh_src;
			S_SH_WR: ord_we = 1'b1;
			S_TAIL: begin
				ord_we    = 1'b1;
				ord_waddr = tail_q;
				ord_wdata = free_q;
			end
			S_EVAL: begin
				case (mode_q)
					pro_pkg::MODE_DISPATCH: begin
						slot_we              = !slot_rdata.flight;
						slot_wdata.flight    = 1'b1;
						slot_wdata.sent_time = now_q;
					end
					pro_pkg::MODE_RETRY: begin
						slot_we              = id_match && slot_rdata.flight;
						slot_wdata.flight    = 1'b0;
						slot_wdata.sent_time = 64'd0;
					end
					pro_pkg::MODE_CLR_FLT: begin
						slot_we              = 1'b1;
						slot_wdata.flight    = 1'b0;
						slot_wdata.sent_time = 64'd0;
					end
					default: slot_we = 1'b0;
				endcase
			end
			default: ord_we = 1'b0;
		endcase
	end

	// Sequencer with counters and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			p_q         <= '0;
			held_q      <= '0;
			sending_q   <= '0;
			bytes_q     <= '0;
			done_q      <= 1'b0;
			max_bytes_q <= pro_pkg::MAX_BYTES_RESET;
			timeout_q   <= pro_pkg::TIMEOUT_MS_RESET;
		end else begin
			done_q <= 1'b0;
			// Configuration writes.
			if (psel && penable && pwrite) begin
				if (paddr[2] == pro_pkg::REG_MAX_BYTES) begin
					max_bytes_q <= pwdata[23:0];
				end else begin
					timeout_q <= pwdata;
				end
			end
			case (state_q)
				S_INIT: begin
					p_q <= p_q + CW'(1);
					if (p_q == LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						mode_q      <= mode;
						idh_q       <= id_high;
						idl_q       <= id_low;
						tag_q       <= payload_tag;
						size_q      <= payload_len;
						prio_q      <= priority_req;
						now_q       <= time_ms;
						found_q     <= '0;
						tmo_q       <= 1'b0;
						status_q    <= pro_pkg::ST_OK;
						p_q         <= '0;
						reg_seen_q  <= 1'b0;
						first_reg_q <= held_q;
						state_q     <= S_ORD;
						case (mode)
							pro_pkg::MODE_PUT: begin
								if (reject) begin
									status_q <= pro_pkg::ST_REJECT;
									done_q   <= 1'b1;
									state_q  <= S_IDLE;
								end
							end
							pro_pkg::MODE_TIMEOUT: begin
								if (timeout_q == 32'd0) begin
									done_q  <= 1'b1;
									state_q <= S_IDLE;
								end
							end
							pro_pkg::MODE_CLR_ALL: begin
								held_q    <= '0;
								bytes_q   <= '0;
								sending_q <= '0;
								done_q    <= 1'b1;
								state_q   <= S_IDLE;
							end
							pro_pkg::MODE_DISPATCH, pro_pkg::MODE_RETRY, pro_pkg::MODE_ACK,
							pro_pkg::MODE_CLR_FLT, pro_pkg::MODE_PEEK_HEAD,
							pro_pkg::MODE_PEEK_REG: begin
								state_q <= S_ORD;
							end
							default: begin
								status_q <= pro_pkg::ST_REJECT;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end
						endcase
					end
				end
				S_ORD: begin
					state_q <= (p_q == held_q) ? S_MISS : S_SLOT;
				end
				S_SLOT: begin
					cur_slot_q <= ord_rdata;
					state_q    <= S_EVAL;
				end
				S_EVAL: begin
					// Default: move on to the next queue position.
					p_q     <= p_q + CW'(1);
					state_q <= S_ORD;
					case (mode_q)
						pro_pkg::MODE_PUT: begin
							if (id_match) begin
								status_q <= pro_pkg::ST_DUP;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else if (!slot_rdata.prio && !reg_seen_q) begin
								reg_seen_q  <= 1'b1;
								first_reg_q <= p_q;
							end
						end
						pro_pkg::MODE_DISPATCH: begin
							if (!slot_rdata.flight) begin
								found_q   <= slot_rdata;
								sending_q <= sending_q + CW'(1);
								done_q    <= 1'b1;
								state_q   <= S_IDLE;
							end
						end
						pro_pkg::MODE_RETRY: begin
							if (id_match) begin
								if (slot_rdata.flight) begin
									sending_q <= sending_q - CW'(1);
								end
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end
						end
						pro_pkg::MODE_ACK: begin
							if (id_match) begin
								bytes_q <= bytes_q - {8'd0, slot_rdata.size};
								if (slot_rdata.flight) begin
									sending_q <= sending_q - CW'(1);
								end
								free_q  <= cur_slot_q;
								tail_q  <= IW'(held_q - CW'(1));
								right_q <= 1'b0;
								p_q     <= p_q;
								state_q <= (p_q == held_q - CW'(1)) ? S_TAIL : S_SH_RD;
							end
						end
						pro_pkg::MODE_PEEK_HEAD: begin
							found_q <= slot_rdata;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
						pro_pkg::MODE_PEEK_REG: begin
							if (!slot_rdata.prio) begin
								found_q <= slot_rdata;
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end
						end
						pro_pkg::MODE_TIMEOUT: begin
							if (timed_out) begin
								tmo_q   <= 1'b1;
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end
						end
						default: state_q <= S_ORD;
					endcase
				end
				S_MISS: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					case (mode_q)
						pro_pkg::MODE_PUT: begin
							if (held_q == FULL) begin
								status_q <= pro_pkg::ST_FULL;
							end else begin
								done_q  <= 1'b0;
								tail_q  <= prio_q ? first_reg_q[IW-1:0] : held_q[IW-1:0];
								state_q <= S_PUT_FREE;
							end
						end
						pro_pkg::MODE_RETRY, pro_pkg::MODE_ACK: begin
							status_q <= pro_pkg::ST_NOT_FOUND;
						end
						pro_pkg::MODE_CLR_FLT: sending_q <= '0;
						pro_pkg::MODE_TIMEOUT: status_q <= pro_pkg::ST_OK;
						default: status_q <= pro_pkg::ST_NO_ENTRY;
					endcase
				end
				S_PUT_FREE: state_q <= S_PUT_WR;
				S_PUT_WR: begin
					free_q  <= ord_rdata;
					right_q <= 1'b1;
					p_q     <= held_q;
					state_q <= (tail_q == held_q[IW-1:0]) ? S_TAIL : S_SH_RD;
				end
				S_SH_RD: state_q <= S_SH_WR;
				S_SH_WR: begin
					p_q     <= {{(CW-IW){1'b0}}, sh_next};
					state_q <= (sh_next == tail_q) ? S_TAIL : S_SH_RD;
				end
				S_TAIL: begin
					if (mode_q == pro_pkg::MODE_PUT) begin
						held_q  <= held_q + CW'(1);
						bytes_q <= bytes_q + {8'd0, size_q};
					end else begin
						held_q <= held_q - CW'(1);
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Outputs.
	assign busy           = (state_q != S_IDLE);
	assign done           = done_q;
	assign status         = status_q;
	assign found_id_high  = found_q.id_high;
	assign found_id_low   = found_q.id_low;
	assign found_tag      = found_q.tag;
	assign found_size     = found_q.size;
	assign found_priority = found_q.prio;
	assign timeout_seen   = tmo_q;
	assign queued_count   = 5'(held_q);
	assign queued_bytes   = bytes_q;
	assign inflight_count = 5'(sending_q);
	assign pready         = 1'b1;
	assign prdata         = (paddr[2] == pro_pkg::REG_TIMEOUT_MS) ? timeout_q
		: {8'd0, max_bytes_q};

`ifndef SYNTH
	// An accepted command either leaves the idle state or raises done.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted command did not start");

	// In-flight entries are a subset of the held entries.
	a_sending_le_held: assert property (@(posedge clk) disable iff (!arst_n)
		sending_q <= held_q)
		else $error("in-flight count exceeds held count");

	// The held count never exceeds the table depth.
	a_held_le_depth: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= FULL)
		else $error("held count exceeds depth");

	// A result is only produced right after a command was accepted or was in progress.
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start)))
		else $error("result strobe without a command");
`endif

endmodule

FILE: rtl/core/pro_slot_ram.sv
// Descriptor slot memory with one write port and one registered read port.
module pro_slot_ram #(
	parameter int DEPTH = pro_pkg::DEPTH_DEFAULT
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  pro_pkg::slot_t           wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output pro_pkg::slot_t           rdata
);

	pro_pkg::slot_t mem [DEPTH];

	// Read-first on a same-address write; read data is registered.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
